/* src/msba_pkg.sv */
package msba_pkg;

	localparam int BUFFER_SIZE = 256;
	localparam int CNT_W = $clog2(BUFFER_SIZE + 1);
	localparam int HEAD_LEN = 5;

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_BEGIN_WAIT = 3'd1,
		MODE_NEXT_WAIT  = 3'd2,
		MODE_RUN_ARB    = 3'd3,
		MODE_NEXT_ARB   = 3'd4
	} mode_t;

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_TIMER = 2'd1;
	localparam logic [1:0] REQ_TX_DONE = 2'd2;

	localparam logic [1:0] TMR_NONE = 2'd0;
	localparam logic [1:0] TMR_STOP = 2'd1;
	localparam logic [1:0] TMR_LOAD = 2'd3;

	localparam logic [2:0] PER_FRAME_GAP = 3'd0;
	localparam logic [2:0] PER_SCAN_WAIT = 3'd1;
	localparam logic [2:0] PER_WINDOW = 3'd2;
	localparam logic [2:0] PER_OLD_SCAN_WAIT = 3'd3;
	localparam logic [2:0] PER_OLD_WINDOW = 3'd4;

	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_SCAN = 2'd1;
	localparam logic [1:0] REPLY_END = 2'd2;

	localparam logic [1:0] RX_KEEP = 2'd0;
	localparam logic [1:0] RX_NORMAL = 2'd1;
	localparam logic [1:0] RX_ABORT = 2'd2;
	localparam logic [1:0] RX_ARB = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_BEGIN = 2'd1;
	localparam logic [1:0] KIND_NEXT = 2'd2;

	localparam logic CFG_SERIAL = 1'b0;
	localparam logic CFG_OLD_VARIANT = 1'b1;

	localparam logic [7:0] ADDR_BCAST = 8'hFD;
	localparam logic [7:0] FN_SCAN = 8'h46;
	localparam logic [7:0] FN_SCAN_OLD = 8'h60;
	localparam logic [7:0] SUB_BEGIN = 8'h01;
	localparam logic [7:0] SUB_NEXT = 8'h02;
	localparam logic [7:0] CRC_BEGIN_LO = 8'h13;
	localparam logic [7:0] CRC_BEGIN_HI = 8'h90;
	localparam logic [7:0] CRC_NEXT_LO = 8'h53;
	localparam logic [7:0] CRC_NEXT_HI = 8'h91;
	localparam logic [7:0] CRC_OLD_BEGIN_LO = 8'h09;
	localparam logic [7:0] CRC_OLD_BEGIN_HI = 8'hF0;
	localparam logic [7:0] CRC_OLD_NEXT_LO = 8'h49;
	localparam logic [7:0] CRC_OLD_NEXT_HI = 8'hF1;
	localparam logic [3:0] PRIO_UNSCANNED = 4'b0110;
	localparam logic [3:0] PRIO_SCANNED = 4'b1111;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_data;
		logic       bus_busy;
	} in_t;

	typedef struct packed {
		logic [1:0] timer_cmd;
		logic [2:0] timer_period;
		logic       send_dominant;
		logic [1:0] reply_kind;
		logic       frame_ready;
		logic [8:0] frame_length;
		logic [1:0] receive_cmd;
		logic       overflow_error;
		logic [2:0] mode_now;
		logic [5:0] window_now;
		logic       lost_now;
	} out_t;

	typedef struct packed {
		logic [31:0] device_serial;
		logic        accept_old_variant;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       old_variant;
	} head_info_t;

	typedef struct packed {
		logic       we;
		logic [2:0] idx;
	} head_wr_t;

endpackage

/* src/modbus_scan_bitwise_arbiter_top.sv */
// Scan arbitration engine for the slave side of an RS-485 bus.
// Input channel (in_valid / in_stall / in_data) carries one event per beat:
// a received byte, a timer expiry or a transmit-complete, with the bus-busy flag.
// Output channel (out_valid / out_stall / out_data) returns exactly one result
// beat per event: timer command, dominant send, reply request, frame handoff,
// receive control and the mode / window / lost status after the event.
// Configuration: cfg_we with cfg_index 0 writes the device serial, index 1 the
// old-variant enable; write only while no events are in flight.
// An accepted event passes the input register, then decision logic, then the
// result register.
// Throughput: one event per cycle while not stalled by out_stall; the decision
// is a single pass of logic over the held state and the head-byte store.
// Reset clears mode, byte count, window, lost flag and the arbitration word;
// the head-byte store is not cleared and is always written before it is used.
// When out_stall holds a waiting result, the result register holds, the input
// register keeps its event, and in_stall rises only once it is also full.
module modbus_scan_bitwise_arbiter_top import msba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic valid_s1;
	in_t  item_s1;
	logic out_valid_q;
	out_t out_data_q;
	out_t result;
	logic advance, step;

	assign advance = !out_valid_q || !out_stall;
	assign step = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SERIAL:      cfg_q.device_serial <= cfg_data;
				CFG_OLD_VARIANT: cfg_q.accept_old_variant <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	msba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* src/msba_head.sv */
module msba_head import msba_pkg::*; (
	input  logic       clk,
	input  head_wr_t   wr,
	input  logic [7:0] rx_data,
	input  logic       accept_old,
	output head_info_t info
);

	logic [7:0] head_q [HEAD_LEN];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			head_q[wr.idx] <= rx_data;
		end
	end

	// classify assuming rx_data is the fifth byte of the frame
	logic is_new, is_old;
	always_comb begin
		info.kind = KIND_NONE;
		info.old_variant = 1'b0;
		is_new = head_q[1] == FN_SCAN;
		is_old = head_q[1] == FN_SCAN_OLD && accept_old;
		if (head_q[0] == ADDR_BCAST) begin
			if (head_q[2] == SUB_BEGIN) begin
				if (is_new && head_q[3] == CRC_BEGIN_LO && rx_data == CRC_BEGIN_HI) begin
					info.kind = KIND_BEGIN;
				end else if (is_old && head_q[3] == CRC_OLD_BEGIN_LO
						&& rx_data == CRC_OLD_BEGIN_HI) begin
					info.kind = KIND_BEGIN;
					info.old_variant = 1'b1;
				end
			end else if (head_q[2] == SUB_NEXT) begin
				if ((is_new && head_q[3] == CRC_NEXT_LO && rx_data == CRC_NEXT_HI)
						|| (is_old && head_q[3] == CRC_OLD_NEXT_LO
						&& rx_data == CRC_OLD_NEXT_HI)) begin
					info.kind = KIND_NEXT;
				end
			end
		end
	end

endmodule

/* src/msba_ctrl.sv */
module msba_ctrl import msba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  in_t  item,
	input  cfg_t cfg,
	output out_t result
);

	mode_t             mode_q, mode_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              oldv_q, oldv_d;
	logic              nscan_q, nscan_d;
	logic [5:0]        win_q, win_d;
	logic              lost_q, lost_d;
	logic [31:0]       word_q, word_d;

	head_wr_t   hwr;
	head_info_t hinfo;

	msba_head u_head (
		.clk        (clk),
		.wr         (hwr),
		.rx_data    (item.rx_data),
		.accept_old (cfg.accept_old_variant),
		.info       (hinfo)
	);

	logic [5:0] win_m1;
	logic       bit_cur, bit_prev, tick;
	logic [CNT_W-1:0] cnt_inc;

	always_comb begin
		mode_d = mode_q;
		cnt_d = cnt_q;
		oldv_d = oldv_q;
		nscan_d = nscan_q;
		win_d = win_q;
		lost_d = lost_q;
		word_d = word_q;
		hwr.we = 1'b0;
		hwr.idx = cnt_q[2:0];
		tick = 1'b0;
		cnt_inc = cnt_q + 1'b1;
		win_m1 = win_q - 6'd1;
		bit_cur = word_q[~win_q[4:0]];
		bit_prev = word_q[~win_m1[4:0]];
		result = '0;

		unique case (mode_q)
			MODE_NORMAL, MODE_BEGIN_WAIT, MODE_NEXT_WAIT, MODE_RUN_ARB, MODE_NEXT_ARB: begin
				priority case (item.req_type)
					REQ_BYTE: begin
						if (mode_q == MODE_NORMAL) begin
							if (cnt_q < CNT_W'(BUFFER_SIZE)) begin
								hwr.we = cnt_q < CNT_W'(HEAD_LEN);
								cnt_d = cnt_inc;
								result.timer_cmd = TMR_LOAD;
								result.timer_period = PER_FRAME_GAP;
								if (cnt_inc == CNT_W'(HEAD_LEN) && hinfo.kind != KIND_NONE) begin
									if (hinfo.kind == KIND_BEGIN) begin
										nscan_d = 1'b1;
										oldv_d = hinfo.old_variant;
										mode_d = MODE_BEGIN_WAIT;
									end else begin
										mode_d = MODE_NEXT_WAIT;
									end
									result.timer_period = oldv_d ? PER_OLD_SCAN_WAIT
										: PER_SCAN_WAIT;
									win_d = '0;
									lost_d = 1'b0;
									word_d = {nscan_d ? PRIO_UNSCANNED : PRIO_SCANNED,
										cfg.device_serial[27:0]};
								end
							end else begin
								result.timer_cmd = TMR_STOP;
								result.overflow_error = 1'b1;
								result.receive_cmd = RX_NORMAL;
								cnt_d = '0;
							end
						end else if (mode_q == MODE_RUN_ARB || mode_q == MODE_NEXT_ARB) begin
							// a byte in a recessive window means someone else won it
							if (win_q >= 6'd1 && win_q <= 6'd32 && !lost_q && bit_prev) begin
								lost_d = 1'b1;
							end
						end
					end
					REQ_TIMER: begin
						if (mode_q == MODE_NORMAL) begin
							if (cnt_q != '0) begin
								result.timer_cmd = TMR_STOP;
								result.frame_ready = 1'b1;
								result.frame_length = 9'(cnt_q);
								result.receive_cmd = RX_NORMAL;
								cnt_d = '0;
							end
						end else if (mode_q == MODE_BEGIN_WAIT || mode_q == MODE_NEXT_WAIT) begin
							result.timer_cmd = TMR_LOAD;
							result.timer_period = oldv_q ? PER_OLD_WINDOW : PER_WINDOW;
							mode_d = (mode_q == MODE_BEGIN_WAIT) ? MODE_RUN_ARB : MODE_NEXT_ARB;
							tick = 1'b1;
						end else begin
							tick = 1'b1;
						end
						if (tick) begin
							if (win_q == 6'd32) begin
								win_d = 6'd33;
							end else if (win_q >= 6'd33) begin
								result.timer_cmd = TMR_STOP;
								result.timer_period = PER_FRAME_GAP;
								mode_d = MODE_NORMAL;
								if (!lost_q) begin
									result.receive_cmd = RX_ABORT;
									if (nscan_q) begin
										nscan_d = 1'b0;
										result.reply_kind = REPLY_SCAN;
									end else begin
										result.reply_kind = REPLY_END;
									end
								end else begin
									result.receive_cmd = RX_NORMAL;
									cnt_d = '0;
								end
							end else begin
								result.send_dominant = !bit_cur && !item.bus_busy && !lost_q;
								win_d = win_q + 6'd1;
							end
						end
					end
					REQ_TX_DONE: begin
						if (mode_q == MODE_NORMAL) begin
							result.receive_cmd = RX_NORMAL;
							cnt_d = '0;
						end else if (mode_q == MODE_RUN_ARB || mode_q == MODE_NEXT_ARB) begin
							result.receive_cmd = RX_ARB;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				mode_d = MODE_NORMAL;
				cnt_d = '0;
				result.receive_cmd = RX_NORMAL;
			end
		endcase

		result.mode_now = mode_d;
		result.window_now = win_d;
		result.lost_now = lost_d;
		hwr.we = hwr.we && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			cnt_q <= '0;
			oldv_q <= 1'b0;
			nscan_q <= 1'b0;
			win_q <= '0;
			lost_q <= 1'b0;
			word_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			cnt_q <= cnt_d;
			oldv_q <= oldv_d;
			nscan_q <= nscan_d;
			win_q <= win_d;
			lost_q <= lost_d;
			word_q <= word_d;
		end
	end

endmodule

/* verif/tb_modbus_scan_bitwise_arbiter_top.sv */
module tb_modbus_scan_bitwise_arbiter_top;
	import msba_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_EVENTS = 310;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PRINT_CAP = 100;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_t;
	typedef logic [8:0] result_fields_t [11];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_SERIAL;
	logic [31:0] cfg_data = '0;

	modbus_scan_bitwise_arbiter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the slave's scan state
	mode_t       md = MODE_NORMAL;
	logic [8:0]  cnt = '0;
	logic [7:0]  head [HEAD_LEN] = '{default: 8'h00};
	logic        old_act = 1'b0;
	logic        unscanned = 1'b0;
	logic [5:0]  win = '0;
	logic        lost_f = 1'b0;
	logic [31:0] arb_w = '0;
	logic [31:0] serial_cfg = '0;
	logic        old_cfg = 1'b0;

	in_t  pending_events [$];
	out_t expected_results [$];
	string result_field [11] = '{"timer_cmd", "timer_period", "send_dominant", "reply_kind",
		"frame_ready", "frame_length", "receive_cmd", "overflow_error", "mode_now",
		"window_now", "lost_now"};

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned events_made = 0;
	int unsigned events_in = 0;
	int unsigned results_seen = 0;
	int unsigned n_answer = 0, n_end = 0, n_dominant = 0, n_handoff = 0, n_overflow = 0;
	logic        in_took = 1'b0;

	task automatic scan_step(input in_t ev, output out_t r);
		logic [1:0] kind;
		logic       tick;
		r = '0;
		kind = KIND_NONE;
		tick = 1'b0;
		case (ev.req_type)
			REQ_BYTE: begin
				if (md == MODE_NORMAL) begin
					if (cnt < BUFFER_SIZE) begin
						if (cnt < HEAD_LEN) head[cnt[2:0]] = ev.rx_data;
						cnt++;
						if (cnt == HEAD_LEN && head[0] == ADDR_BCAST) begin
							if (head[2] == SUB_BEGIN) begin
								if (head[1] == FN_SCAN && head[3] == CRC_BEGIN_LO &&
										head[4] == CRC_BEGIN_HI) begin
									kind = KIND_BEGIN;
									old_act = 1'b0;
								end else if (old_cfg && head[1] == FN_SCAN_OLD &&
										head[3] == CRC_OLD_BEGIN_LO &&
										head[4] == CRC_OLD_BEGIN_HI) begin
									kind = KIND_BEGIN;
									old_act = 1'b1;
								end
							end else if (head[2] == SUB_NEXT) begin
								if ((head[1] == FN_SCAN && head[3] == CRC_NEXT_LO &&
										head[4] == CRC_NEXT_HI) ||
										(old_cfg && head[1] == FN_SCAN_OLD &&
										head[3] == CRC_OLD_NEXT_LO &&
										head[4] == CRC_OLD_NEXT_HI))
									kind = KIND_NEXT;
							end
						end
						r.timer_cmd = TMR_LOAD;
						if (kind == KIND_NONE) begin
							r.timer_period = PER_FRAME_GAP;
						end else begin
							if (kind == KIND_BEGIN) begin
								unscanned = 1'b1;
								md = MODE_BEGIN_WAIT;
							end else begin
								md = MODE_NEXT_WAIT;
							end
							r.timer_period = old_act ? PER_OLD_SCAN_WAIT : PER_SCAN_WAIT;
							win = '0;
							lost_f = 1'b0;
							arb_w = {unscanned ? PRIO_UNSCANNED : PRIO_SCANNED, serial_cfg[27:0]};
						end
					end else begin
						// buffer full: byte dropped, frame discarded
						r.timer_cmd = TMR_STOP;
						r.overflow_error = 1'b1;
						r.receive_cmd = RX_NORMAL;
						cnt = '0;
					end
				end else if (md == MODE_RUN_ARB || md == MODE_NEXT_ARB) begin
					// byte heard during a recessive window means someone else won it
					if (win >= 1 && win <= 32 && !lost_f && arb_w[5'(32 - win)])
						lost_f = 1'b1;
				end
			end
			REQ_TIMER: begin
				if (md == MODE_NORMAL) begin
					if (cnt != 0) begin
						r.timer_cmd = TMR_STOP;
						r.frame_ready = 1'b1;
						r.frame_length = cnt;
						r.receive_cmd = RX_NORMAL;
						cnt = '0;
					end
				end else if (md == MODE_BEGIN_WAIT || md == MODE_NEXT_WAIT) begin
					r.timer_cmd = TMR_LOAD;
					r.timer_period = old_act ? PER_OLD_WINDOW : PER_WINDOW;
					md = (md == MODE_BEGIN_WAIT) ? MODE_RUN_ARB : MODE_NEXT_ARB;
					tick = 1'b1;
				end else begin
					tick = 1'b1;
				end
				if (tick) begin
					if (win == 32) begin
						win = 6'd33;
					end else if (win >= 33) begin
						r.timer_cmd = TMR_STOP;
						r.timer_period = PER_FRAME_GAP;
						md = MODE_NORMAL;
						if (!lost_f) begin
							r.receive_cmd = RX_ABORT;
							r.reply_kind = unscanned ? REPLY_SCAN : REPLY_END;
							unscanned = 1'b0;
						end else begin
							r.receive_cmd = RX_NORMAL;
							cnt = '0;
						end
					end else begin
						if (!arb_w[5'(31 - win)] && !ev.bus_busy && !lost_f)
							r.send_dominant = 1'b1;
						win++;
					end
				end
			end
			REQ_TX_DONE: begin
				if (md == MODE_NORMAL) begin
					r.receive_cmd = RX_NORMAL;
					cnt = '0;
				end else if (md == MODE_RUN_ARB || md == MODE_NEXT_ARB) begin
					r.receive_cmd = RX_ARB;
				end
			end
			default: ;
		endcase
		r.mode_now = md;
		r.window_now = win;
		r.lost_now = lost_f;
	endtask

	function automatic result_fields_t split_result(out_t r);
		return '{9'(r.timer_cmd), 9'(r.timer_period), 9'(r.send_dominant), 9'(r.reply_kind),
			9'(r.frame_ready), r.frame_length, 9'(r.receive_cmd), 9'(r.overflow_error),
			9'(r.mode_now), 9'(r.window_now), 9'(r.lost_now)};
	endfunction

	// input side: predict on each accepted beat, check each delivered one
	out_t           want;
	result_fields_t want_f, got_f;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				scan_step(in_data, want);
				expected_results.push_back(want);
				events_in++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display("%0t: result beat with nothing pending, actual %p", $time, out_data);
				end else begin
					want = expected_results.pop_front();
					want_f = split_result(want);
					got_f = split_result(out_data);
					for (int f = 0; f < 11; f++) begin
						if (want_f[f] !== got_f[f]) begin
							errors++;
							if (errors <= PRINT_CAP)
								$display("%0t: %s expected %0d actual %0d", $time,
									result_field[f], want_f[f], got_f[f]);
						end
					end
					if (want.reply_kind == REPLY_SCAN) n_answer++;
					if (want.reply_kind == REPLY_END) n_end++;
					if (want.send_dominant) n_dominant++;
					if (want.frame_ready) n_handoff++;
					if (want.overflow_error) n_overflow++;
				end
			end
		end
	end

	// sender: bursts of random length with random gaps
	int burst_left = 8;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_events.size() > 0) begin
				in_data <= pending_events.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall style redrawn at random periodically, with periodic long hold-offs
	int unsigned  rx_cycles = 0;
	int           hold_left = 0;
	stall_style_t stall_style = STALL_NONE;

	always @(negedge clk) begin
		rx_cycles++;
		if (rx_cycles % 256 == 0) stall_style = stall_style_t'($urandom_range(0, 2));
		if (rx_cycles % 2500 == 300) hold_left = 150;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				default:     out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	task automatic push_ev(logic [1:0] req, logic [7:0] data, logic busy);
		in_t ev;
		ev.req_type = req;
		ev.rx_data = data;
		ev.bus_busy = busy;
		pending_events.push_back(ev);
		events_made++;
	endtask

	task automatic push_noise();
		push_ev(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
	endtask

	task automatic push_frame(int n_bytes);
		push_ev(REQ_TX_DONE, 8'($urandom), 1'($urandom));
		for (int k = 0; k < n_bytes; k++) push_ev(REQ_BYTE, 8'($urandom), 1'($urandom));
		push_ev(REQ_TIMER, 8'($urandom), 1'($urandom));
	endtask

	// one scan command followed by the full window walk
	task automatic scan_round();
		logic       is_next, old_form;
		int         lose_pct;
		logic [1:0] req;
		logic [7:0] crc_lo, crc_hi;
		logic [7:0] cmd [HEAD_LEN];
		is_next = ($urandom_range(0, 99) < 40);
		old_form = ($urandom_range(0, 99) < 35);
		case ($urandom_range(0, 3))
			0, 1: lose_pct = 0;
			2: lose_pct = 3;
			default: lose_pct = 10;
		endcase
		case ({is_next, old_form})
			2'b00: begin crc_lo = CRC_BEGIN_LO; crc_hi = CRC_BEGIN_HI; end
			2'b01: begin crc_lo = CRC_OLD_BEGIN_LO; crc_hi = CRC_OLD_BEGIN_HI; end
			2'b10: begin crc_lo = CRC_NEXT_LO; crc_hi = CRC_NEXT_HI; end
			default: begin crc_lo = CRC_OLD_NEXT_LO; crc_hi = CRC_OLD_NEXT_HI; end
		endcase
		cmd = '{ADDR_BCAST, old_form ? FN_SCAN_OLD : FN_SCAN, is_next ? SUB_NEXT : SUB_BEGIN,
			crc_lo, crc_hi};
		if ($urandom_range(0, 99) < 12)
			cmd[$urandom_range(0, HEAD_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
		push_ev(REQ_TX_DONE, 8'($urandom), 1'($urandom));
		for (int k = 0; k < HEAD_LEN; k++) push_ev(REQ_BYTE, cmd[k], 1'($urandom));
		repeat ($urandom_range(0, 2)) begin
			req = 2'($urandom_range(0, 2));
			if (req == REQ_TIMER) req = REQ_UNUSED;
			push_ev(req, 8'($urandom), 1'($urandom));
		end
		// wait expiry with window 0, windows 1..31, window 32, then the closing tick
		for (int k = 0; k < 34; k++) begin
			push_ev(REQ_TIMER, 8'($urandom), ($urandom_range(0, 4) == 0));
			if (k < 33) begin
				if ($urandom_range(0, 99) < lose_pct) push_ev(REQ_BYTE, 8'($urandom), 1'($urandom));
				if ($urandom_range(0, 99) < 5) push_ev(REQ_TX_DONE, 8'($urandom), 1'($urandom));
				if ($urandom_range(0, 99) < 3) push_ev(REQ_UNUSED, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_SERIAL) serial_cfg = val;
		else old_cfg = val[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [31:0] serial;
		logic        old_on;
		int unsigned stop_at;
		int          pick;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin serial = 32'h0000_0000; old_on = 1'b0; end
				1: begin serial = 32'hFFFF_FFFF; old_on = 1'b1; end
				2: begin serial = $urandom; old_on = 1'b1; end
				3: begin serial = $urandom; old_on = 1'b0; end
				default: begin serial = $urandom; old_on = 1'b1; end
			endcase
			wait_idle();
			write_reg(CFG_SERIAL, serial);
			write_reg(CFG_OLD_VARIANT, {31'd0, old_on});
			if (ph == 0) begin
				push_ev(REQ_TIMER, 8'h00, 1'b0);   // idle expiry does nothing
				push_ev(REQ_UNUSED, 8'hFF, 1'b1);
				push_ev(REQ_TX_DONE, 8'h00, 1'b0);
				push_ev(REQ_BYTE, 8'h00, 1'b0);
				push_ev(REQ_BYTE, 8'hFF, 1'b1);
				push_ev(REQ_TIMER, 8'hFF, 1'b1);
				// old-form begin is plain data while the old variant is off
				push_ev(REQ_BYTE, ADDR_BCAST, 1'b0);
				push_ev(REQ_BYTE, FN_SCAN_OLD, 1'b0);
				push_ev(REQ_BYTE, SUB_BEGIN, 1'b1);
				push_ev(REQ_BYTE, CRC_OLD_BEGIN_LO, 1'b0);
				push_ev(REQ_BYTE, CRC_OLD_BEGIN_HI, 1'b0);
				push_ev(REQ_TIMER, 8'h00, 1'b0);
				// begin command with a bad check byte
				push_ev(REQ_BYTE, ADDR_BCAST, 1'b0);
				push_ev(REQ_BYTE, FN_SCAN, 1'b0);
				push_ev(REQ_BYTE, SUB_BEGIN, 1'b0);
				push_ev(REQ_BYTE, CRC_BEGIN_LO, 1'b0);
				push_ev(REQ_BYTE, CRC_NEXT_HI, 1'b0);
				push_ev(REQ_TX_DONE, 8'hFF, 1'b1);
			end
			stop_at = events_made + PHASE_EVENTS;
			if (ph == 1) push_frame(BUFFER_SIZE);      // exactly full buffer
			if (ph == 3) push_frame(BUFFER_SIZE + $urandom_range(1, 4));
			while (events_made < stop_at) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) scan_round();
				else if (pick < 75) push_frame($urandom_range(1, 12));
				else push_noise();
			end
		end
		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_results.size());
		end
		$display("Ran %0d events through 5 register settings, %0d results checked, %0d errors",
			events_in, results_seen, errors);
		$display("Scan answers %0d, end-of-scan %0d, dominant bytes %0d, frames %0d, overflows %0d",
			n_answer, n_end, n_dominant, n_handoff, n_overflow);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
